// File: sv/scv_pkg.sv
// Shared constants, codes and types for the strided 3x3 convolution block.
`default_nettype none
package scv_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_STEP   = 8;
  localparam int KROWS      = 3;
  localparam int KCOLS      = 3;
  localparam int KTAPS      = KROWS * KCOLS;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WID_W   = 11;
  localparam int HGT_W   = 13;
  localparam int STEP_W  = 4;
  localparam int WIDX_W  = 4;
  localparam int SMP_W   = 16;
  localparam int PROD_W  = 2 * SMP_W;
  localparam int RSUM_W  = PROD_W + 2;
  localparam int SUM_W   = 40;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = HGT_W;

  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_STEP   = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef logic [KTAPS-1:0][SMP_W-1:0] kvec_t;

  // item leaving the raster control stage
  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [WIDX_W-1:0] widx;
    logic [SMP_W-1:0]  smp;
    logic [COL_W-1:0]  col;
    logic              emit;
    logic [ROW_W-1:0]  orow;
    logic [COL_W-1:0]  ocol;
    logic              last;
  } fe_t;

  // result bookkeeping that travels beside the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic             last;
  } meta_t;

endpackage
`default_nettype wire

// File: sv/scv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/scv_ctrl.sv
// Configuration registers, raster position and stride bookkeeping.
`default_nettype none
module scv_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          acc,
  input  wire logic                          cfg_valid,
  input  wire logic [scv_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [scv_pkg::CDATA_W-1:0]   cfg_data,
  input  wire logic                          command,
  input  wire logic [scv_pkg::WIDX_W-1:0]    weight_index,
  input  wire logic signed [scv_pkg::SMP_W-1:0] sample_value,
  output scv_pkg::fe_t                       fe,
  output logic                               rd_en,
  output logic [scv_pkg::COL_W-1:0]          rd_addr
);
  import scv_pkg::*;

  logic [WID_W-1:0]  width;
  logic [HGT_W-1:0]  height;
  logic [STEP_W-1:0] step;
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [STEP_W-1:0] c_ph;
  logic [STEP_W-1:0] r_ph;
  logic [COL_W-1:0]  c_idx;
  logic [ROW_W-1:0]  r_idx;

  logic [COL_W-1:0]  col_count_next;
  logic [ROW_W-1:0]  row_count_next;
  logic [STEP_W-1:0] c_ph_next;
  logic [STEP_W-1:0] r_ph_next;
  logic [COL_W-1:0]  c_idx_next;
  logic [ROW_W-1:0]  r_idx_next;
  fe_t               fe_next;

  logic [WID_W-1:0]  w_in;
  logic [HGT_W-1:0]  h_in;
  logic [STEP_W-1:0] s_in;
  logic              col_last;
  logic              row_last;
  logic              col_ge;
  logic              row_ge;

  assign w_in = cfg_data[WID_W-1:0];
  assign h_in = cfg_data;
  assign s_in = cfg_data[STEP_W-1:0];

  assign col_last = ({1'b0, col_count} == width - WID_W'(1));
  assign row_last = ({1'b0, row_count} == height - HGT_W'(1));
  assign col_ge   = (col_count >= COL_W'(KCOLS - 1));
  assign row_ge   = (row_count >= ROW_W'(KROWS - 1));

  assign rd_en   = acc;
  assign rd_addr = col_count;

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    c_ph_next      = c_ph;
    r_ph_next      = r_ph;
    c_idx_next     = c_idx;
    r_idx_next     = r_idx;
    if (col_last) begin
      col_count_next = '0;
      c_ph_next      = '0;
      c_idx_next     = '0;
      if (row_last) begin
        row_count_next = '0;
        r_ph_next      = '0;
        r_idx_next     = '0;
      end else begin
        row_count_next = row_count + ROW_W'(1);
        if (row_ge) begin
          if (r_ph == step - STEP_W'(1)) begin
            r_ph_next  = '0;
            r_idx_next = r_idx + ROW_W'(1);
          end else begin
            r_ph_next = r_ph + STEP_W'(1);
          end
        end
      end
    end else begin
      col_count_next = col_count + COL_W'(1);
      if (col_ge) begin
        if (c_ph == step - STEP_W'(1)) begin
          c_ph_next  = '0;
          c_idx_next = c_idx + COL_W'(1);
        end else begin
          c_ph_next = c_ph + STEP_W'(1);
        end
      end
    end

    fe_next.valid = acc;
    fe_next.cmd   = command;
    fe_next.widx  = weight_index;
    fe_next.smp   = sample_value;
    fe_next.col   = col_count;
    fe_next.emit  = col_ge && row_ge && (c_ph == '0) && (r_ph == '0);
    fe_next.orow  = r_idx;
    fe_next.ocol  = c_idx;
    fe_next.last  = ((WID_W'(col_count) + WID_W'(step)) >= width) &&
                    ((HGT_W'(row_count) + HGT_W'(step)) >= height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= WID_W'(1024);
      height    <= HGT_W'(1024);
      step      <= STEP_W'(1);
      col_count <= '0;
      row_count <= '0;
      c_ph      <= '0;
      r_ph      <= '0;
      c_idx     <= '0;
      r_idx     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH: begin
          if (w_in < WID_W'(KCOLS)) width <= WID_W'(KCOLS);
          else if (w_in > WID_W'(MAX_WIDTH)) width <= WID_W'(MAX_WIDTH);
          else width <= w_in;
        end
        CFG_HEIGHT: begin
          if (h_in < HGT_W'(KROWS)) height <= HGT_W'(KROWS);
          else if (h_in > HGT_W'(MAX_HEIGHT)) height <= HGT_W'(MAX_HEIGHT);
          else height <= h_in;
        end
        CFG_STEP: begin
          if (s_in == '0) step <= STEP_W'(1);
          else if (s_in > STEP_W'(MAX_STEP)) step <= STEP_W'(MAX_STEP);
          else step <= s_in;
        end
        default: begin
        end
      endcase
      if (cfg_index inside {CFG_WIDTH, CFG_HEIGHT, CFG_STEP}) begin
        col_count <= '0;
        row_count <= '0;
        c_ph      <= '0;
        r_ph      <= '0;
        c_idx     <= '0;
        r_idx     <= '0;
      end
    end else if (acc && command == CMD_SAMPLE) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      c_ph      <= c_ph_next;
      r_ph      <= r_ph_next;
      c_idx     <= c_idx_next;
      r_idx     <= r_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe <= '0;
    end else if (en) begin
      fe <= fe_next;
    end
  end

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col_count} < width)
    else $error("column position beyond row width");
  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row_count} < height)
    else $error("row position beyond frame height");
  a_phase_in_step: assert property (@(posedge clk) disable iff (rst)
    (c_ph < step) && (r_ph < step))
    else $error("stride phase out of range");
`endif

endmodule
`default_nettype wire

// File: sv/scv_window.sv
// Two line buffers, the 3x3 sample window and the kernel weight registers.
`default_nettype none
module scv_window (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire scv_pkg::fe_t             fe,
  input  wire logic                     rd_en,
  input  wire logic [scv_pkg::COL_W-1:0] rd_addr,
  output scv_pkg::kvec_t                win,
  output scv_pkg::kvec_t                wts
);
  import scv_pkg::*;

  logic [SMP_W-1:0] lo_q;
  logic [SMP_W-1:0] hi_q;
  logic             shift_en;
  logic             load_en;
  logic [KROWS-1:0][SMP_W-1:0] column;

  assign shift_en = en && fe.valid && (fe.cmd == CMD_SAMPLE);
  assign load_en  = en && fe.valid && (fe.cmd == CMD_LOAD) && (fe.widx < WIDX_W'(KTAPS));

  assign column[0] = lo_q;
  assign column[1] = hi_q;
  assign column[2] = fe.smp;

  // older row
  scv_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WIDTH)) u_ram_lo (
    .clk   (clk),
    .we    (shift_en),
    .waddr (fe.col),
    .wdata (hi_q),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (lo_q)
  );

  // newer row
  scv_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WIDTH)) u_ram_hi (
    .clk   (clk),
    .we    (shift_en),
    .waddr (fe.col),
    .wdata (fe.smp),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (hi_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (shift_en) begin
      for (int r = 0; r < KROWS; r++) begin
        for (int c = 0; c < KCOLS - 1; c++) begin
          win[r*KCOLS+c] <= win[r*KCOLS+c+1];
        end
        win[r*KCOLS+KCOLS-1] <= column[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wts <= '0;
    end else if (load_en) begin
      wts[fe.widx] <= fe.smp;
    end
  end

endmodule
`default_nettype wire

// File: sv/scv_mac.sv
// Nine parallel multipliers, adder tree and the result register.
`default_nettype none
module scv_mac (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire scv_pkg::fe_t                  fe,
  input  wire scv_pkg::kvec_t                win,
  input  wire scv_pkg::kvec_t                wts,
  output logic                               result_valid,
  output logic signed [scv_pkg::SUM_W-1:0]   sum_value,
  output logic [scv_pkg::ROW_W-1:0]          out_row,
  output logic [scv_pkg::COL_W-1:0]          out_col,
  output logic                               last
);
  import scv_pkg::*;

  meta_t m2;
  meta_t m3;
  meta_t m4;
  logic signed [PROD_W-1:0] prod [KTAPS];
  logic signed [RSUM_W-1:0] rsum [KROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2           <= '0;
      m3           <= '0;
      m4           <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      m2.valid     <= fe.valid && (fe.cmd == CMD_SAMPLE) && fe.emit;
      m2.orow      <= fe.orow;
      m2.ocol      <= fe.ocol;
      m2.last      <= fe.last;
      m3           <= m2;
      m4           <= m3;
      result_valid <= m4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < KTAPS; k++) begin
        prod[k] <= $signed(win[k]) * $signed(wts[k]);
      end
      for (int r = 0; r < KROWS; r++) begin
        rsum[r] <= RSUM_W'(prod[r*KCOLS]) + RSUM_W'(prod[r*KCOLS+1]) +
                   RSUM_W'(prod[r*KCOLS+2]);
      end
      sum_value <= SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
      out_row   <= m4.orow;
      out_col   <= m4.ocol;
      last      <= m4.last;
    end
  end

endmodule
`default_nettype wire

// File: sv/strided_conv2d.sv
// Strided 3x3 valid correlation over a raster sample stream.
// Input channel (pixel_valid / pixel_stall): command 0 loads kernel weight
// weight_index with sample_value (Q2.14), command 1 delivers the next image
// sample (Q8.8) in raster order. One item is taken every clock while pixel_stall is low.
// Result channel (result_valid / result_stall): one item per window whose
// top-left corner lies on the stride grid, with sum_value (Q18.22), its
// output row and column, and last on the final window of the frame.
// A result reaches the result ports through the line buffer read with the input
// register, then window shift, multiply, row sums, final sum.
// Throughput: 1 item per cycle while no result is stalled, set by the single-port
// read of the two line buffer RAMs and the nine parallel multipliers.
// When the result register holds an item that the receiver stalls, the
// whole pipeline holds and pixel_stall is raised; otherwise the block takes
// an item in the same cycle the result is taken.
// Configuration (cfg_valid / cfg_ready, always ready) writes image_width,
// image_height or step_size and restarts the frame; write only when idle.
// Reset clears counters, window and weights and sets width 1024, height
// 1024, step 1. Line buffers need no clearing.
`default_nettype none
module strided_conv2d (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             pixel_valid,
  output logic                                  pixel_stall,
  input  wire logic                             command,
  input  wire logic [scv_pkg::WIDX_W-1:0]       weight_index,
  input  wire logic signed [scv_pkg::SMP_W-1:0] sample_value,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic signed [scv_pkg::SUM_W-1:0]      sum_value,
  output logic [scv_pkg::ROW_W-1:0]             out_row,
  output logic [scv_pkg::COL_W-1:0]             out_col,
  output logic                                  last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scv_pkg::CIDX_W-1:0]       cfg_index,
  input  wire logic [scv_pkg::CDATA_W-1:0]      cfg_data
);
  import scv_pkg::*;

  logic             en;
  logic             acc;
  fe_t              fe;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  kvec_t            win;
  kvec_t            wts;

  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;
  assign acc         = pixel_valid && en;
  assign cfg_ready   = 1'b1;

  scv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .acc          (acc),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .weight_index (weight_index),
    .sample_value (sample_value),
    .fe           (fe),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  scv_window u_window (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .fe      (fe),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .win     (win),
    .wts     (wts)
  );

  scv_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .fe           (fe),
    .win          (win),
    .wts          (wts),
    .result_valid (result_valid),
    .sum_value    (sum_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (result_valid && result_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for strided_conv2d: random raster frames against a window predictor.
module tb_top;
  import scv_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1000;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } conv_result_t;

  class conv_board;
    bit [SMP_W-1:0] line_buf [KROWS-1][MAX_WIDTH];
    bit [SMP_W-1:0] win [KROWS][KCOLS];
    bit [SMP_W-1:0] taps [KTAPS];
    int unsigned row_pos, col_pos, width, height, step;
    conv_result_t expected_sums [$];
    int errors;

    function new();
      width  = MAX_WIDTH;
      height = 1024;
      step   = 1;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        CFG_WIDTH:  width  = fit(data[WID_W-1:0], KCOLS, MAX_WIDTH);
        CFG_HEIGHT: height = fit(data[HGT_W-1:0], KROWS, MAX_HEIGHT);
        CFG_STEP:   step   = fit(data[STEP_W-1:0], 1, MAX_STEP);
        default:    return;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    // take one accepted item: load a weight, or advance the raster and queue the window sum it completes
    function void take_item(logic cmd, logic [WIDX_W-1:0] widx, logic [SMP_W-1:0] smp);
      bit [SMP_W-1:0] colv [KROWS];
      int unsigned row, col, r0, c0;
      longint acc;
      conv_result_t res;
      if (cmd == CMD_LOAD) begin
        if (widx < KTAPS) taps[widx] = smp;
        return;
      end
      row = row_pos;
      col = col_pos;
      for (int r = 0; r < KROWS - 1; r++) colv[r] = line_buf[r][col];
      colv[KROWS-1] = smp;
      for (int r = 0; r < KROWS - 2; r++) line_buf[r][col] = line_buf[r+1][col];
      line_buf[KROWS-2][col] = smp;
      for (int r = 0; r < KROWS; r++) begin
        for (int c = 0; c < KCOLS - 1; c++) win[r][c] = win[r][c+1];
        win[r][KCOLS-1] = colv[r];
      end
      if (row + 1 >= KROWS && col + 1 >= KCOLS) begin
        r0 = row + 1 - KROWS;
        c0 = col + 1 - KCOLS;
        if (r0 % step == 0 && c0 % step == 0) begin
          acc = 0;
          for (int r = 0; r < KROWS; r++)
            for (int c = 0; c < KCOLS; c++)
              acc += longint'($signed(win[r][c])) * longint'($signed(taps[r*KCOLS+c]));
          res.sum  = acc[SUM_W-1:0];
          res.row  = ROW_W'(r0 / step);
          res.col  = COL_W'(c0 / step);
          res.last = (r0 == ((height - KROWS) / step) * step) &&
                     (c0 == ((width - KCOLS) / step) * step);
          expected_sums.push_back(res);
        end
      end
      col++;
      if (col >= width) begin
        col = 0;
        row++;
        if (row >= height) row = 0;
      end
      row_pos = row;
      col_pos = col;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("mismatch: %s", msg);
    endtask

    task check_sum(logic [SUM_W-1:0] sum, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                   logic lst);
      conv_result_t res;
      if (expected_sums.size() == 0) begin
        report($sformatf("unexpected item row %0d col %0d sum %h", row, col, sum));
        return;
      end
      res = expected_sums.pop_front();
      if (sum !== res.sum)
        report($sformatf("row %0d col %0d sum %h, want %h", res.row, res.col, sum, res.sum));
      if (row !== res.row) report($sformatf("out_row %0d, want %0d", row, res.row));
      if (col !== res.col) report($sformatf("out_col %0d, want %0d", col, res.col));
      if (lst !== res.last)
        report($sformatf("row %0d col %0d last %b, want %b", res.row, res.col, lst, res.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic command = CMD_LOAD;
  logic [WIDX_W-1:0] weight_index = '0;
  logic signed [SMP_W-1:0] sample_value = '0;
  logic result_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [CDATA_W-1:0] cfg_data = '0;
  logic pixel_stall, result_valid, last, cfg_ready;
  logic signed [SUM_W-1:0] sum_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  logic hold_req = 1'b0;
  logic calm = 1'b0;
  int counted;
  conv_board board = new();

  strided_conv2d uut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .command(command), .weight_index(weight_index), .sample_value(sample_value),
    .result_valid(result_valid), .result_stall(result_stall),
    .sum_value(sum_value), .out_row(out_row), .out_col(out_col), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic push_item(logic cmd, logic [WIDX_W-1:0] idx, logic [SMP_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid  <= 1'b1;
    command      <= cmd;
    weight_index <= idx;
    sample_value <= v;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    board.take_item(cmd, idx, v);
  endtask

  task automatic stream(int n);
    logic [WIDX_W-1:0] idx;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        idx = WIDX_W'($urandom_range(0, 15));
        push_item(CMD_LOAD, idx, SMP_W'($urandom));
        if (idx < KTAPS) counted++;
      end else begin
        push_item(CMD_SAMPLE, WIDX_W'($urandom), pick_sample());
        counted++;
      end
    end
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (board.expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic set_regs(int w, int h, int s);
    write_reg(CFG_WIDTH, CDATA_W'(w));
    write_reg(CFG_HEIGHT, CDATA_W'(h));
    write_reg(CFG_STEP, CDATA_W'(s));
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall runs, quiet stretches and one long hold-off
  initial begin : sink
    int run_left;
    int hold_left;
    logic stalling;
    run_left  = 0;
    hold_left = 0;
    stalling  = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall)
        board.check_sum(sum_value, out_row, out_col, last);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (calm) begin
        result_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          if (!stalling) run_left = $urandom_range(1, 12);
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(8, 20);
          else run_left = $urandom_range(1, 3);
        end
        run_left--;
        result_stall <= stalling;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main
    logic [SMP_W-1:0] first_taps [KTAPS];
    int w, h, s, frame, n;
    first_taps = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000,
                   16'h4000, 16'hC000, 16'h3039, 16'hFFFE};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme weights, ignored loads, a few samples at reset geometry
    for (int k = 0; k < KTAPS; k++) push_item(CMD_LOAD, WIDX_W'(k), first_taps[k]);
    push_item(CMD_LOAD, 4'd9, 16'h1234);
    push_item(CMD_LOAD, 4'hF, 16'h8001);
    push_item(CMD_SAMPLE, 4'h0, 16'h7FFF);
    push_item(CMD_SAMPLE, 4'hF, 16'h8000);
    push_item(CMD_SAMPLE, 4'h5, 16'h0000);
    wait_idle();

    // zero writes clamp to the smallest 3x3 frame, stride 1
    set_regs(0, 0, 0);
    for (int k = 0; k < KROWS * KCOLS; k++)
      push_item(CMD_SAMPLE, WIDX_W'(k), k[0] ? 16'h7FFF : 16'h8000);
    wait_idle();

    // receiver holds off while the sender keeps offering
    set_regs(8, 6, 1);
    hold_req <= 1'b1;
    stream(48);
    wait_idle();

    // widest row (masked and clamped to the maximum), start of the first row
    set_regs(13'h1FFF, 3, 1);
    stream(40);
    wait_idle();

    // tallest frame and largest stride, partial frame
    set_regs(3, 13'h1FFF, 13'h000F);
    stream(150);
    wait_idle();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 15) == 0) begin
        write_reg(CFG_UNUSED, CDATA_W'($urandom));
        cfg_valid <= 1'b0;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(0, 8191);
          h = $urandom_range(0, 8191);
          s = $urandom_range(0, 8191);
        end else begin
          w = $urandom_range(3, 14);
          h = $urandom_range(3, 9);
          s = $urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        end
        set_regs(w, h, s);
      end
      frame = board.width * board.height;
      n = (frame <= 200) ? $urandom_range(frame, 2 * frame) : $urandom_range(20, 200);
      stream(n);
      wait_idle();
    end

    if (board.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
